[sv/mhpq_pkg.sv]
// Package for the max-heap priority queue: operation and status codes,
// default sizes and the controller-to-datapath command types. No dependencies.
`timescale 1ns / 1ps
package mhpq_pkg;
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF = 16;
  localparam int unsigned TAG_BITS_DEF = 16;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_BUILD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Datapath commands issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_LOAD    = 4'd1,  // capture input word
    CMD_WR_NEW  = 4'd2,  // write input word at slot count, count++
    CMD_RD_LAST = 4'd3,  // read slot count-1
    CMD_WR_ROOT = 4'd4,  // write read data to root, count--, pos=0
    CMD_RD_POS  = 4'd5,  // read slot pos into cur
    CMD_RD_A    = 4'd6,  // read address a (parent or left child)
    CMD_RD_B    = 4'd7,  // read right child, capture a
    CMD_DECIDE  = 4'd8,  // capture b (if any) and choose
    CMD_WR_X    = 4'd9,  // write cur to chosen slot
    CMD_WR_Y    = 4'd10, // write chosen entry to pos, move pos
    CMD_BLD_NXT = 4'd11, // next build node
    CMD_RD_TOP  = 4'd12, // read root for result
    CMD_DONE    = 4'd13  // capture root into result
  } cmd_t;

  typedef struct packed {
    logic up_mode;   // sift-up rather than sift-down
    logic strict_pk; // build: node wins ties
  } mode_t;

  typedef struct packed {
    logic swap;      // decided to swap
    logic at_top;    // sift-up at root
    logic no_child;  // sift-down at leaf
    logic full;
    logic empty;
    logic bld_done;  // no more build nodes
    logic few;       // count below two for build
  } stat_t;
endpackage

[sv/mhpq_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mhpq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/mhpq_datapath.sv]
// Datapath of the heap: entry RAM, count, position and compare logic.
// Depends on mhpq_pkg and mhpq_ram.
`timescale 1ns / 1ps
module mhpq_datapath #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = mhpq_pkg::TAG_BITS_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  mhpq_pkg::cmd_t      cmd,
  input  mhpq_pkg::mode_t     mode,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [TAG_BITS-1:0] in_tag,
  output mhpq_pkg::stat_t     stat,
  output logic [KEY_BITS-1:0] res_key,
  output logic [TAG_BITS-1:0] res_tag,
  output logic [CW-1:0]       res_count
);
  localparam int unsigned EW = KEY_BITS + TAG_BITS;

  logic [CW-1:0] count;
  logic [CW:0]   pos;      // one bit wider so child indexes do not wrap
  logic [CW:0]   bnode;    // next build node plus one
  logic [EW-1:0] cur, ea, eb, nw;
  logic [CW:0]   ia, ib, pick;
  logic          has_b, swp;
  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic          rdpos_d;

  mhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [CW:0] cnt_w, left, right, parent;
  assign cnt_w  = {1'b0, count};
  assign left   = {pos[CW-1:0], 1'b1};
  assign right  = left + 1'b1;
  assign parent = (pos - 1'b1) >> 1;

  always_comb begin
    we    = 1'b0;
    addr  = pos[AW-1:0];
    wdata = cur;
    case (cmd)
      mhpq_pkg::CMD_WR_NEW: begin
        we = 1'b1; addr = count[AW-1:0]; wdata = nw;
      end
      mhpq_pkg::CMD_RD_LAST: addr = AW'(count - 1'b1);
      mhpq_pkg::CMD_WR_ROOT: begin
        we = 1'b1; addr = '0; wdata = rdata;
      end
      mhpq_pkg::CMD_RD_A: addr = mode.up_mode ? parent[AW-1:0] : left[AW-1:0];
      mhpq_pkg::CMD_RD_B: addr = right[AW-1:0];
      mhpq_pkg::CMD_WR_X: begin
        we = 1'b1; addr = pick[AW-1:0]; wdata = cur;
      end
      mhpq_pkg::CMD_WR_Y: begin
        we = 1'b1; addr = pos[AW-1:0];
        wdata = (pick == ia) ? ea : eb;
      end
      mhpq_pkg::CMD_RD_TOP: addr = '0;
      default: ;
    endcase
  end

  logic [KEY_BITS-1:0] kc, ka, kb;
  assign kc = cur[EW-1 -: KEY_BITS];
  assign ka = ea[EW-1 -: KEY_BITS];
  assign kb = rdata[EW-1 -: KEY_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd)
        mhpq_pkg::CMD_WR_NEW:  count <= count + 1'b1;
        mhpq_pkg::CMD_WR_ROOT: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // Build reads the node on CMD_RD_POS; its data arrives in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) rdpos_d <= 1'b0;
    else     rdpos_d <= (cmd == mhpq_pkg::CMD_RD_POS);
  end

  always_ff @(posedge clk) begin
    case (cmd)
      mhpq_pkg::CMD_LOAD: begin
        nw    <= {in_key, in_tag};
        bnode <= (cnt_w >> 1);
      end
      mhpq_pkg::CMD_WR_NEW: begin
        pos <= cnt_w;
        cur <= nw;
      end
      mhpq_pkg::CMD_WR_ROOT: begin
        pos <= '0;
        cur <= rdata;
      end
      mhpq_pkg::CMD_RD_POS: ;
      mhpq_pkg::CMD_RD_A: begin
        ia    <= mode.up_mode ? parent : left;
        ib    <= right;
        has_b <= !mode.up_mode && (right < cnt_w);
      end
      mhpq_pkg::CMD_RD_B: ea <= rdata;
      mhpq_pkg::CMD_DECIDE: begin
        eb <= rdata;
        if (mode.up_mode) begin
          pick <= ia;
          swp  <= ka < kc;
        end else if (mode.strict_pk) begin
          if (has_b && kb > ka && kb > kc) begin
            pick <= ib; swp <= 1'b1;
          end else begin
            pick <= ia; swp <= ka > kc;
          end
        end else begin
          if (has_b && kb > ka) begin
            pick <= ib; swp <= kc < kb;
          end else begin
            pick <= ia; swp <= kc < ka;
          end
        end
      end
      mhpq_pkg::CMD_WR_Y: pos <= pick;
      mhpq_pkg::CMD_BLD_NXT: begin
        pos   <= bnode - 1'b1;
        bnode <= bnode - 1'b1;
      end
      mhpq_pkg::CMD_RD_TOP: ;
      mhpq_pkg::CMD_DONE: begin
        res_count <= count;
        if (count == '0) begin
          res_key <= '0; res_tag <= '0;
        end else begin
          res_key <= rdata[EW-1 -: KEY_BITS];
          res_tag <= rdata[TAG_BITS-1:0];
        end
      end
      default: ;
    endcase
    // The build node becomes the entry being sifted once its data arrives.
    if (rdpos_d) cur <= rdata;
  end

  always_comb begin
    stat.swap     = swp;
    stat.at_top   = (pos == '0);
    stat.no_child = !(left < cnt_w);
    stat.full     = (cnt_w >= (CW+1)'(CAPACITY));
    stat.empty    = (count == '0);
    stat.bld_done = (bnode == '0);
    stat.few      = (count < CW'(2));
  end
endmodule

[sv/mhpq_ctrl.sv]
// Controller state machine sequencing the heap operations.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps
module mhpq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_op,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output mhpq_pkg::cmd_t  cmd,
  output mhpq_pkg::mode_t mode,
  input  mhpq_pkg::stat_t stat
);
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DISP  = 13'b0000000000010,
    S_LAST  = 13'b0000000000100,
    S_ROOT  = 13'b0000000001000,
    S_RDA   = 13'b0000000010000,
    S_RDB   = 13'b0000000100000,
    S_DEC   = 13'b0000001000000,
    S_CHK   = 13'b0000010000000,
    S_WRY   = 13'b0000100000000,
    S_BNXT  = 13'b0001000000000,
    S_BRD   = 13'b0010000000000,
    S_TOP   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] op, status, res_status;
  logic       wait_rd;

  // A finished result waits in its own registers, so the next word can be
  // taken meanwhile; that word is held at S_TOP until the result is consumed.
  assign in_ready   = (state == S_IDLE);
  assign out_status = res_status;

  always_comb begin
    state_next = state;
    cmd        = mhpq_pkg::CMD_NONE;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd = mhpq_pkg::CMD_LOAD; state_next = S_DISP;
      end
      S_DISP: begin
        if (op == mhpq_pkg::OP_PUSH || op == mhpq_pkg::OP_APPEND) begin
          if (stat.full) state_next = S_TOP;
          else begin
            cmd = mhpq_pkg::CMD_WR_NEW;
            state_next = (op == mhpq_pkg::OP_PUSH) ? S_CHK : S_TOP;
          end
        end else if (op == mhpq_pkg::OP_POP) begin
          state_next = stat.empty ? S_TOP : S_LAST;
        end else begin
          state_next = stat.few ? S_TOP : S_BNXT;
        end
      end
      S_LAST: begin cmd = mhpq_pkg::CMD_RD_LAST; state_next = S_ROOT; end
      S_ROOT: begin cmd = mhpq_pkg::CMD_WR_ROOT; state_next = S_CHK; end
      S_CHK: begin
        if (mode.up_mode ? stat.at_top : stat.no_child)
          state_next = (op == mhpq_pkg::OP_BUILD) ? S_BNXT : S_TOP;
        else begin
          cmd = mhpq_pkg::CMD_RD_A; state_next = S_RDA;
        end
      end
      S_RDA: begin cmd = mhpq_pkg::CMD_RD_B; state_next = S_RDB; end
      S_RDB: begin cmd = mhpq_pkg::CMD_DECIDE; state_next = S_DEC; end
      S_DEC: begin
        if (stat.swap) begin
          cmd = mhpq_pkg::CMD_WR_X; state_next = S_WRY;
        end else
          state_next = (op == mhpq_pkg::OP_BUILD) ? S_BNXT : S_TOP;
      end
      S_WRY: begin cmd = mhpq_pkg::CMD_WR_Y; state_next = S_CHK; end
      S_BNXT: begin
        if (stat.bld_done) state_next = S_TOP;
        else begin cmd = mhpq_pkg::CMD_BLD_NXT; state_next = S_BRD; end
      end
      S_BRD: begin
        if (wait_rd) state_next = S_CHK;
        else cmd = mhpq_pkg::CMD_RD_POS;
      end
      S_TOP: begin
        if (!out_valid || out_ready) begin
          cmd = mhpq_pkg::CMD_RD_TOP; state_next = S_DONE;
        end
      end
      S_DONE: begin cmd = mhpq_pkg::CMD_DONE; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  assign mode.up_mode   = (op == mhpq_pkg::OP_PUSH);
  assign mode.strict_pk = (op == mhpq_pkg::OP_BUILD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wait_rd   <= 1'b0;
    end else begin
      state   <= state_next;
      wait_rd <= (state == S_BRD) && !wait_rd;
      if (state == S_DONE) out_valid <= 1'b1;
      else if (out_ready)  out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_ready) begin
      op <= in_op;
      status <= mhpq_pkg::ST_OK;
    end else if (state == S_DISP) begin
      if ((op == mhpq_pkg::OP_PUSH || op == mhpq_pkg::OP_APPEND) && stat.full)
        status <= mhpq_pkg::ST_FULL;
      else if (op == mhpq_pkg::OP_POP && stat.empty)
        status <= mhpq_pkg::ST_EMPTY;
    end
    if (state == S_DONE) res_status <= status;
  end
endmodule

[sv/max_heap_priority_queue.sv]
// Top level of the binary max-heap priority queue.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_datapath and mhpq_ram.
//
// The queue holds up to CAPACITY (key, tag) entries in one single-port RAM
// with registered read, laid out as an array heap. Each input word carries an
// operation: push (append and sift up), pop (move the last entry to the root
// and sift down, larger child first, left on ties), append (store unordered)
// or build (bottom-up heapify). Every word yields one result word with the
// root entry (zero when empty), the count and a status: full drops an insert,
// empty ignores a pop. One word is processed at a time; the next word may be
// taken while a result waits, and it then holds before its root read until
// that result is consumed. The operations share the single RAM port, used
// once per cycle. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = mhpq_pkg::TAG_BITS_DEF,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [KEY_BITS-1:0] entry_key,
  input  logic [TAG_BITS-1:0] entry_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KEY_BITS-1:0] top_key,
  output logic [TAG_BITS-1:0] top_tag,
  output logic [CW-1:0]       entry_count,
  output logic [1:0]          status
);
  mhpq_pkg::cmd_t  cmd;
  mhpq_pkg::mode_t mode;
  mhpq_pkg::stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_op(operation), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(status), .cmd(cmd), .mode(mode), .stat(stat)
  );

  mhpq_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .mode(mode), .in_key(entry_key),
    .in_tag(entry_tag), .stat(stat), .res_key(top_key), .res_tag(top_tag),
    .res_count(entry_count)
  );
endmodule

[sv/mhpq_checker.sv]
// Port-level checks for the heap queue, bound to the top level.
// Depends on max_heap_priority_queue.
`timescale 1ns / 1ps
module mhpq_checker #(
  parameter int unsigned CW = 11
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [CW-1:0] entry_count,
  input logic [1:0]    status
);
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= mhpq_pkg::ST_EMPTY) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(entry_count) && $stable(status))
    else $error("result moved");
endmodule

bind max_heap_priority_queue mhpq_checker #(.CW(CW)) u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .entry_count(entry_count),
  .status(status)
);

[sim/tb_max_heap_priority_queue.sv]
// Testbench for max_heap_priority_queue: directed table, then random words
// checked against an in-bench heap predictor. Depends on mhpq_pkg and the RTL.
`timescale 1ns / 1ps
module tb_max_heap_priority_queue;
  localparam int unsigned DEPTH = mhpq_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] tag;
    logic [10:0] cnt;
    logic [1:0]  st;
  } heap_result_t;

  typedef struct {
    logic [1:0]   op;
    logic [15:0]  key;
    logic [15:0]  tag;
    bit           typed;
    heap_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = mhpq_pkg::OP_PUSH;
  logic [15:0] entry_key = '0;
  logic [15:0] entry_tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] top_key;
  logic [15:0] top_tag;
  logic [10:0] entry_count;
  logic [1:0]  status;

  max_heap_priority_queue dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .entry_key(entry_key), .entry_tag(entry_tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .top_key(top_key), .top_tag(top_tag),
    .entry_count(entry_count), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the heap.
  logic [15:0] heap_keys [DEPTH];
  logic [15:0] heap_tags [DEPTH];
  int unsigned heap_size = 0;

  heap_result_t pending_results[$];
  int  err_count = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [15:0] k, t;
    k = heap_keys[a]; t = heap_tags[a];
    heap_keys[a] = heap_keys[b]; heap_tags[a] = heap_tags[b];
    heap_keys[b] = k; heap_tags[b] = t;
  endfunction

  function automatic void heapify_node(int unsigned pos);
    int unsigned l, r, best;
    forever begin
      l = 2 * pos + 1;
      r = l + 1;
      best = pos;
      if (l < heap_size && heap_keys[l] > heap_keys[best]) best = l;
      if (r < heap_size && heap_keys[r] > heap_keys[best]) best = r;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function automatic heap_result_t apply_heap_op(logic [1:0] op, logic [15:0] key,
                                                 logic [15:0] tag);
    heap_result_t res;
    int unsigned pos, up, l, r, pick, i;
    res = '0;
    res.st = mhpq_pkg::ST_OK;
    if (op == mhpq_pkg::OP_PUSH || op == mhpq_pkg::OP_APPEND) begin
      if (heap_size >= DEPTH) begin
        res.st = mhpq_pkg::ST_FULL;
      end else begin
        pos = heap_size;
        heap_keys[pos] = key;
        heap_tags[pos] = tag;
        heap_size++;
        if (op == mhpq_pkg::OP_PUSH) begin
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!(heap_keys[up] < heap_keys[pos])) break;
            swap_slots(up, pos);
            pos = up;
          end
        end
      end
    end else if (op == mhpq_pkg::OP_POP) begin
      if (heap_size == 0) begin
        res.st = mhpq_pkg::ST_EMPTY;
      end else begin
        heap_size--;
        heap_keys[0] = heap_keys[heap_size];
        heap_tags[0] = heap_tags[heap_size];
        pos = 0;
        forever begin
          l = 2 * pos + 1;
          r = l + 1;
          if (l >= heap_size) break;
          pick = l;
          if (r < heap_size && heap_keys[r] > heap_keys[l]) pick = r;
          if (!(heap_keys[pos] < heap_keys[pick])) break;
          swap_slots(pos, pick);
          pos = pick;
        end
      end
    end else begin
      i = heap_size / 2;
      while (i > 0) begin
        i--;
        heapify_node(i);
      end
    end
    if (heap_size > 0) begin
      res.key = heap_keys[0];
      res.tag = heap_tags[0];
    end
    res.cnt = heap_size[10:0];
    return res;
  endfunction

  // Offers one word and waits for it to be taken. A random gap may come first.
  task automatic send_word(logic [1:0] op, logic [15:0] key, logic [15:0] tag,
                           bit typed = 1'b0, heap_result_t want = '0);
    heap_result_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    entry_key <= key;
    entry_tag <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_heap_op(op, key, tag);
    pending_results = {pending_results, (typed ? want : res)};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    heap_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{key: top_key, tag: top_tag, cnt: entry_count, st: status};
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, got);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.key !== want.key) begin
          $display("%0t: top_key expected %h actual %h", $time, want.key, got.key);
          err_count++;
        end
        if (got.tag !== want.tag) begin
          $display("%0t: top_tag expected %h actual %h", $time, want.tag, got.tag);
          err_count++;
        end
        if (got.cnt !== want.cnt) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.cnt, got.cnt);
          err_count++;
        end
        if (got.st !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          err_count++;
        end
      end
    end
  end

  function automatic stim_row_t row(logic [1:0] op, logic [15:0] key, logic [15:0] tag,
                                    bit typed = 1'b0, heap_result_t want = '0);
    stim_row_t r;
    r.op = op; r.key = key; r.tag = tag; r.typed = typed; r.want = want;
    return r;
  endfunction

  task automatic random_words(int n, int unsigned size_cap);
    int unsigned pick;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (heap_size > size_cap)
        op = (pick < 70) ? mhpq_pkg::OP_POP : mhpq_pkg::OP_PUSH;
      else if (pick < 45) op = mhpq_pkg::OP_PUSH;
      else if (pick < 75) op = mhpq_pkg::OP_POP;
      else if (pick < 90) op = mhpq_pkg::OP_APPEND;
      else op = mhpq_pkg::OP_BUILD;
      // Narrow keys now and then so that ties come up often.
      send_word(op, ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom),
                16'($urandom));
    end
  endtask

  initial begin
    stim_row_t table_rows[$];
    table_rows = '{
      row(mhpq_pkg::OP_POP, 16'h1234, 16'h5678, 1,
          '{16'h0, 16'h0, 11'd0, mhpq_pkg::ST_EMPTY}),
      row(mhpq_pkg::OP_BUILD, 16'h0, 16'h0, 1, '{16'h0, 16'h0, 11'd0, mhpq_pkg::ST_OK}),
      row(mhpq_pkg::OP_PUSH, 16'hFFFF, 16'hFFFF, 1,
          '{16'hFFFF, 16'hFFFF, 11'd1, mhpq_pkg::ST_OK}),
      row(mhpq_pkg::OP_BUILD, 16'h0, 16'h0, 1,
          '{16'hFFFF, 16'hFFFF, 11'd1, mhpq_pkg::ST_OK}),
      row(mhpq_pkg::OP_PUSH, 16'h0000, 16'h0000, 1,
          '{16'hFFFF, 16'hFFFF, 11'd2, mhpq_pkg::ST_OK}),
      // Equal key does not displace the root.
      row(mhpq_pkg::OP_PUSH, 16'hFFFF, 16'h0001, 1,
          '{16'hFFFF, 16'hFFFF, 11'd3, mhpq_pkg::ST_OK}),
      row(mhpq_pkg::OP_APPEND, 16'h8000, 16'hAAAA),
      row(mhpq_pkg::OP_APPEND, 16'h9000, 16'h5555),
      row(mhpq_pkg::OP_APPEND, 16'h7FFF, 16'h0F0F),
      row(mhpq_pkg::OP_PUSH, 16'h1234, 16'hF0F0),
      row(mhpq_pkg::OP_POP, 16'h0, 16'h0), row(mhpq_pkg::OP_POP, 16'h0, 16'h0),
      row(mhpq_pkg::OP_BUILD, 16'h0, 16'h0),
      row(mhpq_pkg::OP_POP, 16'h0, 16'h0), row(mhpq_pkg::OP_POP, 16'h0, 16'h0),
      row(mhpq_pkg::OP_POP, 16'h0, 16'h0), row(mhpq_pkg::OP_POP, 16'h0, 16'h0),
      row(mhpq_pkg::OP_POP, 16'h0, 16'h0),
      row(mhpq_pkg::OP_POP, 16'h0, 16'h0, 1, '{16'h0, 16'h0, 11'd0, mhpq_pkg::ST_EMPTY}),
      // Unordered appends with ties, then build.
      row(mhpq_pkg::OP_APPEND, 16'h0005, 16'h0001),
      row(mhpq_pkg::OP_APPEND, 16'h0005, 16'h0002),
      row(mhpq_pkg::OP_APPEND, 16'h0005, 16'h0003),
      row(mhpq_pkg::OP_APPEND, 16'h0009, 16'h0004),
      row(mhpq_pkg::OP_BUILD, 16'h0, 16'h0), row(mhpq_pkg::OP_POP, 16'h0, 16'h0)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i])
      send_word(table_rows[i].op, table_rows[i].key, table_rows[i].tag,
                table_rows[i].typed, table_rows[i].want);

    random_words(50, 120);

    // Receiver holds off while the sender keeps offering.
    hold_req = 1'b1;
    random_words(30, 120);
    wait_drained();

    // Fill to capacity, then insert into a full heap and rebuild it.
    while (heap_size < DEPTH)
      send_word(($urandom_range(0, 9) == 0) ? mhpq_pkg::OP_PUSH : mhpq_pkg::OP_APPEND,
                16'($urandom), 16'($urandom));
    send_word(mhpq_pkg::OP_PUSH, 16'hFFFF, 16'hFFFF);
    send_word(mhpq_pkg::OP_APPEND, 16'h0, 16'h0);
    send_word(mhpq_pkg::OP_BUILD, 16'h0, 16'h0);
    send_word(mhpq_pkg::OP_PUSH, 16'h1, 16'h1);
    random_words(20, 1000);
    send_word(mhpq_pkg::OP_BUILD, 16'h0, 16'h0);

    // A short mixed stretch, then a final stretch with no idling on either side.
    random_words(20, 60);
    idle_on = 1'b0;
    random_words(40, 60);

    wait_drained();
    if (err_count == 0)
      $display("tb_max_heap_priority_queue: clean");
    else
      $display("tb_max_heap_priority_queue: errors");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_max_heap_priority_queue: errors");
    $finish;
  end
endmodule
